// File: design/dckf_pkg.sv
// shared constants and types for the dominant color key finder
package dckf_pkg;

  localparam int unsigned PIXEL_W = 8;
  localparam int unsigned PEAK_W  = 24;
  localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};

  // control from the sequencer to the peak tracker
  typedef struct packed {
    logic clear;
    logic sample;
  } peak_ctl_t;

endpackage

// File: design/dckf_pixel_if.sv
// pixel request channel: one rgb pixel with its end-of-frame mark
interface dckf_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       frame_end;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, frame_end, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, frame_end, output ready);
endinterface

// File: design/dckf_key_if.sv
// key request channel: key color and peak count of one frame
interface dckf_key_if;
  logic        valid;
  logic        ready;
  logic [7:0]  key_red;
  logic [7:0]  key_green;
  logic [7:0]  key_blue;
  logic [23:0] peak_count;

  modport source (output valid, key_red, key_green, key_blue, peak_count, input ready);
  modport sink   (input valid, key_red, key_green, key_blue, peak_count, output ready);
endinterface

// File: design/dckf_ram.sv
// generic single-write, single-read ram with registered read data
module dckf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/dckf_quant.sv
// channel quantizer: value / bucket width by reciprocal multiply, clamped to last bucket
module dckf_quant #(
  parameter int unsigned BUCKET_COUNT = 16
) (
  input  logic [7:0]                      value,
  output logic [$clog2(BUCKET_COUNT)-1:0] index
);

  localparam int unsigned IdxW     = $clog2(BUCKET_COUNT);
  localparam int unsigned BinWidth = 256 / BUCKET_COUNT;
  // ceil(2^16 / width) gives an exact floor for every 8-bit value
  localparam int unsigned Recip    = (65536 + BinWidth - 1) / BinWidth;

  logic [24:0] prod;
  logic [8:0]  quot;

  assign prod = 25'(value) * 25'(Recip);
  assign quot = prod[24:16];

  always_comb begin
    if (quot >= 9'(BUCKET_COUNT)) begin
      index = IdxW'(BUCKET_COUNT - 1);
    end else begin
      index = IdxW'(quot);
    end
  end

endmodule

// File: design/dckf_peak.sv
// running maximum over the bin scan, first strictly greater count wins
module dckf_peak #(
  parameter int unsigned COUNT_WIDTH = 24,
  parameter int unsigned IDX_W       = 4
) (
  input  logic                   clk,
  input  dckf_pkg::peak_ctl_t    ctl,
  input  logic [COUNT_WIDTH-1:0] count,
  input  logic [IDX_W-1:0]       idx_r,
  input  logic [IDX_W-1:0]       idx_g,
  input  logic [IDX_W-1:0]       idx_b,
  output logic [COUNT_WIDTH-1:0] best,
  output logic [IDX_W-1:0]       best_r,
  output logic [IDX_W-1:0]       best_g,
  output logic [IDX_W-1:0]       best_b
);
  import dckf_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      best   <= '0;
      best_r <= '0;
      best_g <= '0;
      best_b <= '0;
    end else if (ctl.sample && (count > best)) begin
      best   <= count;
      best_r <= idx_r;
      best_g <= idx_g;
      best_b <= idx_b;
    end
  end

endmodule

// File: design/dominant_color_key_finder_unit.sv
// Dominant color key finder. Each accepted pixel is quantized per channel to BUCKET_COUNT
// levels and its bin in a BUCKET_COUNT^3 histogram ram is incremented, saturating at the
// COUNT_WIDTH maximum. An ordinary pixel passes the register, quantize, ram read and ram
// write back steps through the single read-modify-write path of the histogram ram, and
// pixel.ready is low meanwhile. A pixel with frame_end set adds a scan of every bin: one
// bin is read per cycle in red, green, blue order through one comparator, each bin is
// zeroed right after it is read, and the key request then waits in an output register
// until taken. After reset the ram is cleared one bin per cycle, every bin, before the
// first pixel is accepted.
module dominant_color_key_finder_unit #(
  parameter int unsigned BUCKET_COUNT = 16,
  parameter int unsigned COUNT_WIDTH  = 24
) (
  input  logic               clk,
  input  logic               rst,
  dckf_pixel_if.sink         pixel,
  dckf_key_if.source         key
);
  import dckf_pkg::*;

  localparam int unsigned BinCount = BUCKET_COUNT * BUCKET_COUNT * BUCKET_COUNT;
  localparam int unsigned AddrW    = $clog2(BinCount);
  localparam int unsigned IdxW     = $clog2(BUCKET_COUNT);
  localparam int unsigned BinWidth = 256 / BUCKET_COUNT;
  localparam int unsigned HalfBin  = BinWidth / 2;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_QUANT = 8'b0000_0100,
    S_READ  = 8'b0000_1000,
    S_WRITE = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_TAIL  = 8'b0100_0000,
    S_PUSH  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [7:0]       px_r, px_g, px_b;
  logic             px_end;
  logic [IdxW-1:0]  qr, qg, qb;
  logic [IdxW-1:0]  qr_in, qg_in, qb_in;
  logic [AddrW-1:0] pix_addr;
  logic [AddrW-1:0] scan_addr;
  logic [AddrW-1:0] prev_addr;
  logic [IdxW-1:0]  sr, sg, sb;
  logic [IdxW-1:0]  pr, pg, pb;
  logic             pend;

  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [AddrW-1:0]       ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  peak_ctl_t              peak_ctl;
  logic [COUNT_WIDTH-1:0] best;
  logic [IdxW-1:0]        best_r, best_g, best_b;
  logic [31:0]            best_ext;

  logic       out_valid;
  logic [7:0] out_r, out_g, out_b;
  logic [PEAK_W-1:0] out_peak;
  logic       push_ok;
  logic       last_bin;

  dckf_quant #(.BUCKET_COUNT(BUCKET_COUNT)) u_quant_r (.value(px_r), .index(qr_in));
  dckf_quant #(.BUCKET_COUNT(BUCKET_COUNT)) u_quant_g (.value(px_g), .index(qg_in));
  dckf_quant #(.BUCKET_COUNT(BUCKET_COUNT)) u_quant_b (.value(px_b), .index(qb_in));

  assign pix_addr = AddrW'((32'(qr) * BUCKET_COUNT + 32'(qg)) * BUCKET_COUNT + 32'(qb));

  dckf_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BinCount)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = prev_addr;
    ram_wdata = '0;
    ram_raddr = (state == S_SCAN) ? scan_addr : pix_addr;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = scan_addr;
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = pix_addr;
        // saturating increment
        ram_wdata = (&ram_rdata) ? ram_rdata : ram_rdata + 1'b1;
      end
      S_SCAN, S_TAIL: begin
        ram_we = pend;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    peak_ctl.clear  = (state == S_WRITE);
    peak_ctl.sample = ((state == S_SCAN) || (state == S_TAIL)) && pend;
  end

  dckf_peak #(.COUNT_WIDTH(COUNT_WIDTH), .IDX_W(IdxW)) u_peak (
    .clk    (clk),
    .ctl    (peak_ctl),
    .count  (ram_rdata),
    .idx_r  (pr),
    .idx_g  (pg),
    .idx_b  (pb),
    .best   (best),
    .best_r (best_r),
    .best_g (best_g),
    .best_b (best_b)
  );

  assign best_ext = 32'(best);
  assign push_ok  = !out_valid || key.ready;
  assign last_bin = (scan_addr == AddrW'(BinCount - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      scan_addr <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_PUSH && push_ok) begin
        out_valid <= 1'b1;
      end else if (key.valid && key.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          scan_addr <= scan_addr + 1'b1;
          if (last_bin) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pixel.valid) begin
            state <= S_QUANT;
          end
        end
        S_QUANT: begin
          state <= S_READ;
        end
        S_READ: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          scan_addr <= '0;
          pend      <= 1'b0;
          state     <= px_end ? S_SCAN : S_IDLE;
        end
        S_SCAN: begin
          pend      <= 1'b1;
          scan_addr <= scan_addr + 1'b1;
          if (last_bin) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (push_ok) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && pixel.valid) begin
      px_r   <= pixel.pixel_red;
      px_g   <= pixel.pixel_green;
      px_b   <= pixel.pixel_blue;
      px_end <= pixel.frame_end;
    end
    if (state == S_QUANT) begin
      qr <= qr_in;
      qg <= qg_in;
      qb <= qb_in;
    end
    if (state == S_WRITE) begin
      sr <= '0;
      sg <= '0;
      sb <= '0;
    end else if (state == S_SCAN) begin
      // prev index tracks the bin whose data returns next cycle
      prev_addr <= scan_addr;
      pr <= sr;
      pg <= sg;
      pb <= sb;
      if (sb == IdxW'(BUCKET_COUNT - 1)) begin
        sb <= '0;
        if (sg == IdxW'(BUCKET_COUNT - 1)) begin
          sg <= '0;
          sr <= sr + 1'b1;
        end else begin
          sg <= sg + 1'b1;
        end
      end else begin
        sb <= sb + 1'b1;
      end
    end
    if (state == S_PUSH && push_ok) begin
      out_r    <= 8'(32'(best_r) * BinWidth + HalfBin);
      out_g    <= 8'(32'(best_g) * BinWidth + HalfBin);
      out_b    <= 8'(32'(best_b) * BinWidth + HalfBin);
      out_peak <= (best_ext > 32'(PEAK_MAX)) ? PEAK_MAX : best_ext[PEAK_W-1:0];
    end
  end

  assign pixel.ready    = (state == S_IDLE);
  assign key.valid      = out_valid;
  assign key.key_red    = out_r;
  assign key.key_green  = out_g;
  assign key.key_blue   = out_b;
  assign key.peak_count = out_peak;

endmodule
